/* src/swm_pkg.sv */
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_BITS  = 32;
  localparam int CFG_BITS     = 7;
  localparam int RESET_WINDOW = 3;

  // flags a cell shows its left neighbor
  typedef struct packed {
    logic valid;
    logic eq;
    logic le;
  } swm_up_t;

  // flags a cell shows its right neighbor, after the removal shift
  typedef struct packed {
    logic valid;
    logic lt;
  } swm_dn_t;

endpackage

`default_nettype wire

/* src/swm_ifs.sv */
`default_nettype none

interface swm_sample_if #(
  parameter int SampleBits = swm_pkg::SAMPLE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
  parameter int SampleBits = swm_pkg::SAMPLE_BITS
);
  logic                       valid;
  logic                       ready;
  logic signed [SampleBits:0] median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink   (input valid, input median_doubled, output ready);
endinterface

`default_nettype wire

/* src/swm_cell.sv */
`default_nettype none

module swm_cell #(
  parameter int SampleBits = swm_pkg::SAMPLE_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clear_i,
  input  wire logic                         step_i,
  input  wire logic                         rm_en_i,
  input  wire logic signed [SampleBits-1:0] sample_i,
  input  wire logic signed [SampleBits-1:0] old_i,
  input  wire logic signed [SampleBits-1:0] left_val_i,
  input  wire swm_pkg::swm_dn_t             left_dn_i,
  input  wire logic signed [SampleBits-1:0] right_val_i,
  input  wire swm_pkg::swm_up_t             right_up_i,
  output logic signed [SampleBits-1:0]      val_o,
  output swm_pkg::swm_up_t                  up_o,
  output logic signed [SampleBits-1:0]      shift_val_o,
  output swm_pkg::swm_dn_t                  dn_o
);
  import swm_pkg::*;

  logic signed [SampleBits-1:0] val_q, val_d;
  logic                         valid_q, valid_d;
  logic                         le, eq, gt, geq;
  logic                         vp, lep, lt, is_p;
  logic signed [SampleBits-1:0] cp;

  always_comb begin
    le  = val_q <= sample_i;
    eq  = val_q == old_i;
    gt  = val_q > old_i;
    // removal takes the last instance of the outgoing value
    geq = rm_en_i && valid_q && (gt || (eq && !(right_up_i.valid && right_up_i.eq)));
    vp  = geq ? right_up_i.valid : valid_q;
    cp  = geq ? right_val_i : val_q;
    lep = geq ? right_up_i.le : le;
    lt  = vp && lep;
    is_p = !lt && left_dn_i.lt;
    if (lt) begin
      val_d   = cp;
      valid_d = 1'b1;
    end else if (is_p) begin
      val_d   = sample_i;
      valid_d = 1'b1;
    end else begin
      val_d   = left_val_i;
      valid_d = left_dn_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (step_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      val_q <= val_d;
    end
  end

  assign val_o       = val_q;
  assign up_o        = '{valid: valid_q, eq: eq, le: le};
  assign shift_val_o = cp;
  assign dn_o        = '{valid: vp, lt: lt};

endmodule

`default_nettype wire

/* src/swm_sorter.sv */
`default_nettype none

module swm_sorter #(
  parameter int MaxWindow  = swm_pkg::MAX_WINDOW,
  parameter int SampleBits = swm_pkg::SAMPLE_BITS,
  parameter int AddrBits   = 6
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clear_i,
  input  wire logic                         step_i,
  input  wire logic                         rm_en_i,
  input  wire logic signed [SampleBits-1:0] sample_i,
  input  wire logic signed [SampleBits-1:0] old_i,
  input  wire logic [AddrBits-1:0]          lo_idx_i,
  input  wire logic [AddrBits-1:0]          hi_idx_i,
  output logic signed [SampleBits-1:0]      lo_o,
  output logic signed [SampleBits-1:0]      hi_o
);
  import swm_pkg::*;

  localparam int IdxW = $clog2(MaxWindow + 1);

  logic signed [SampleBits-1:0] val_w   [MaxWindow+1];
  logic signed [SampleBits-1:0] shift_w [MaxWindow+1];
  swm_up_t                      up_w    [MaxWindow+1];
  swm_dn_t                      dn_w    [MaxWindow+1];

  assign val_w[MaxWindow]   = '0;
  assign up_w[MaxWindow]    = '{valid: 1'b0, eq: 1'b0, le: 1'b0};
  assign shift_w[0]         = '0;
  assign dn_w[0]            = '{valid: 1'b1, lt: 1'b1};

  for (genvar j = 0; j < MaxWindow; j++) begin : g_cell
    swm_cell #(
      .SampleBits(SampleBits)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (clear_i),
      .step_i     (step_i),
      .rm_en_i    (rm_en_i),
      .sample_i   (sample_i),
      .old_i      (old_i),
      .left_val_i (shift_w[j]),
      .left_dn_i  (dn_w[j]),
      .right_val_i(val_w[j+1]),
      .right_up_i (up_w[j+1]),
      .val_o      (val_w[j]),
      .up_o       (up_w[j]),
      .shift_val_o(shift_w[j+1]),
      .dn_o       (dn_w[j+1])
    );
  end

  assign lo_o = val_w[IdxW'(lo_idx_i)];
  assign hi_o = val_w[IdxW'(hi_idx_i)];

endmodule

`default_nettype wire

/* src/sliding_window_median.sv */
// Running median filter over the last window_size signed samples.
//
// sample_i takes one sample per item (valid/ready). median_o gives one item
// per sample once the window is full: twice the median, i.e. the middle
// value doubled for an odd window, the sum of the two middle values for an
// even window. The first window_size-1 samples after reset or after a
// window_size write give no result.
// cfg_we_i/cfg_wdata_i write window_size (0 acts as 1, values above
// MaxWindow saturate); a write empties the window.
// Results: taking a sample steps the sorter and marks its result pending;
// the result is registered into the output register once that is free.
// Throughput: one sample per cycle while sample_i.ready is high (see Stall);
// the sorted window lives in a row of MaxWindow cells that delete the
// outgoing sample and insert the new one in the same cycle, the outgoing
// sample coming from a circular buffer read one item ahead.
// Reset: window_size 3, window empty, no result pending.
// Stall: one result waits in the output register and one more in the
// pending stage; sample_i.ready drops only while both are held.
`default_nettype none

module sliding_window_median #(
  parameter int MaxWindow  = swm_pkg::MAX_WINDOW,
  parameter int SampleBits = swm_pkg::SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  swm_sample_if.sink                         sample_i,
  swm_median_if.source                       median_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [swm_pkg::CFG_BITS-1:0]  cfg_wdata_i
);
  import swm_pkg::*;

  localparam int CntW     = $clog2(MaxWindow + 1);
  localparam int AW       = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int ResetWin = (MaxWindow < RESET_WINDOW) ? MaxWindow : RESET_WINDOW;

  logic [CntW-1:0]              win_q, win_cfg;
  logic [CntW-1:0]              fill_q, fill_d;
  logic [CntW-1:0]              wp_inc;
  logic [AW-1:0]                wp_q, wp_d, wp_next, rd_addr;
  logic                         pend_q, pend_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [SampleBits:0]   out_data_q;
  logic signed [SampleBits-1:0] rd_q;
  logic signed [SampleBits-1:0] mem [MaxWindow];
  logic signed [SampleBits-1:0] lo, hi;
  logic [AW-1:0]                lo_idx, hi_idx;
  logic                         step, load, in_ready, rm_en, produce;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      win_cfg = CntW'(1);
    end else if (int'(cfg_wdata_i) > MaxWindow) begin
      win_cfg = CntW'(MaxWindow);
    end else begin
      win_cfg = CntW'(cfg_wdata_i);
    end
  end

  assign load     = pend_q && (!out_valid_q || median_o.ready);
  assign in_ready = !pend_q || load;
  assign step     = sample_i.valid && in_ready;
  assign rm_en    = fill_q == win_q;
  assign produce  = rm_en || (CntW'(fill_q + 1'b1) == win_q);
  assign wp_inc   = CntW'(wp_q) + CntW'(1);
  assign wp_next  = (wp_inc >= win_q) ? '0 : AW'(wp_inc);
  assign lo_idx   = AW'((win_q - 1'b1) >> 1);
  assign hi_idx   = AW'(win_q >> 1);

  always_comb begin
    fill_d      = fill_q;
    wp_d        = wp_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (median_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      pend_d = 1'b0;
    end
    if (cfg_we_i) begin
      fill_d = '0;
      wp_d   = '0;
      pend_d = 1'b0;
    end else if (step) begin
      fill_d = rm_en ? fill_q : CntW'(fill_q + 1'b1);
      wp_d   = wp_next;
      pend_d = produce;
    end
  end

  assign rd_addr = wp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= CntW'(ResetWin);
      fill_q      <= '0;
      wp_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= win_cfg;
      end
      fill_q      <= fill_d;
      wp_q        <= wp_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // circular buffer, read one item ahead with write bypass
  always_ff @(posedge clk_i) begin
    if (step) begin
      mem[wp_q] <= sample_i.sample;
    end
    if (step && (rd_addr == wp_q)) begin
      rd_q <= sample_i.sample;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= {lo[SampleBits-1], lo} + {hi[SampleBits-1], hi};
    end
  end

  swm_sorter #(
    .MaxWindow (MaxWindow),
    .SampleBits(SampleBits),
    .AddrBits  (AW)
  ) u_sorter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_we_i),
    .step_i  (step && !cfg_we_i),
    .rm_en_i (rm_en),
    .sample_i(sample_i.sample),
    .old_i   (rd_q),
    .lo_idx_i(lo_idx),
    .hi_idx_i(hi_idx),
    .lo_o    (lo),
    .hi_o    (hi)
  );

  assign sample_i.ready          = in_ready;
  assign median_o.valid          = out_valid_q;
  assign median_o.median_doubled = out_data_q;

endmodule

`default_nettype wire

/* src/swm_checker.sv */
`default_nettype none

module swm_checker #(
  parameter int SampleBits = swm_pkg::SAMPLE_BITS
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [SampleBits:0]    out_data_i,
  input wire logic                   cfg_we_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  a_rise_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a preceding item");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

  a_ready_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_ready_i)
    else $error("input not ready after window write");

endmodule

bind sliding_window_median swm_checker #(
  .SampleBits(SampleBits)
) u_swm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (sample_i.valid),
  .in_ready_i (sample_i.ready),
  .out_valid_i(median_o.valid),
  .out_ready_i(median_o.ready),
  .out_data_i (median_o.median_doubled),
  .cfg_we_i   (cfg_we_i)
);

`default_nettype wire

/* bench/sliding_window_median_tb.sv */
`default_nettype none

module sliding_window_median_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 3000;
  localparam int SettleCycles = 4;

  class median_board;
    logic [swm_pkg::CFG_BITS-1:0]          win_reg;
    logic signed [swm_pkg::SAMPLE_BITS-1:0] arrival [swm_pkg::MAX_WINDOW];
    logic signed [swm_pkg::SAMPLE_BITS-1:0] window_sorted [$];
    logic signed [swm_pkg::SAMPLE_BITS:0]   median_due [$];
    int unsigned fill;
    int unsigned wp;
    int errors;
    int checked;

    function new();
      win_reg = swm_pkg::CFG_BITS'(swm_pkg::RESET_WINDOW);
      fill = 0;
      wp = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned span();
      if (win_reg == 0) return 1;
      if (win_reg > swm_pkg::MAX_WINDOW) return swm_pkg::MAX_WINDOW;
      return win_reg;
    endfunction

    function void set_window(logic [swm_pkg::CFG_BITS-1:0] v);
      win_reg = v;
      fill = 0;
      wp = 0;
      window_sorted.delete();
    endfunction

    function void note_sample(logic signed [swm_pkg::SAMPLE_BITS-1:0] s);
      int unsigned w;
      int pos;
      logic signed [swm_pkg::SAMPLE_BITS:0] lo;
      logic signed [swm_pkg::SAMPLE_BITS:0] hi;
      w = span();
      if (wp >= w) wp = 0;
      // drop the outgoing sample, one instance of its value
      if (fill == w) begin
        pos = 0;
        while (pos < window_sorted.size() && window_sorted[pos] != arrival[wp]) pos++;
        if (pos < window_sorted.size()) window_sorted.delete(pos);
        fill--;
      end
      pos = 0;
      while (pos < window_sorted.size() && window_sorted[pos] <= s) pos++;
      window_sorted.insert(pos, s);
      fill++;
      arrival[wp] = s;
      wp++;
      if (wp >= w) wp = 0;
      if (fill == w) begin
        if (w % 2 != 0) begin
          lo = window_sorted[w / 2];
          hi = lo;
        end else begin
          lo = window_sorted[w / 2 - 1];
          hi = window_sorted[w / 2];
        end
        median_due.insert(median_due.size(), lo + hi);
      end
    endfunction

    function void check_result(logic signed [swm_pkg::SAMPLE_BITS:0] got);
      logic signed [swm_pkg::SAMPLE_BITS:0] want;
      if (median_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected median, expected none, actual %0d", $time, got);
        return;
      end
      want = median_due.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: median mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return median_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [swm_pkg::CFG_BITS-1:0] cfg_wdata;

  swm_sample_if sin ();
  swm_median_if mout ();

  sliding_window_median dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sin),
    .median_o   (mout),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  median_board board = new();
  bit calm = 1'b0;
  int accepted = 0;
  int settings = 0;
  int stall_cycles = 0;

  logic signed [31:0] edge_cases [20] = '{
    32'sd0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd1,
    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
    32'sh80000000, 32'sh80000000, 32'sh80000000,
    32'sd5, 32'sd5, -32'sd5, 32'sd5, 32'sd5,
    32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1
  };

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && mout.valid && mout.ready) begin
      board.check_result(mout.median_doubled);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (sin.valid && sin.ready) || (mout.valid && mout.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("sliding_window_median regression: fail");
      $finish;
    end
  end

  initial begin
    mout.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        mout.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end else begin
        mout.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
  end

  function automatic logic signed [31:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return 32'($signed($urandom_range(0, 12)) - 6);
      4: begin
        if ($urandom_range(0, 1) != 0) return 32'sh7fffffff - 32'($urandom_range(0, 2));
        return 32'sh80000000 + 32'($urandom_range(0, 2));
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(input logic signed [31:0] s);
    sin.valid <= 1'b1;
    sin.sample <= s;
    do @(posedge clk_i); while (!sin.ready);
    board.note_sample(s);
    accepted++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int n);
    sin.valid <= 1'b0;
    sin.sample <= $urandom;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    sin.valid <= 1'b0;
    do @(negedge clk_i); while (board.pending() != 0);
  endtask

  task automatic set_size(input logic [swm_pkg::CFG_BITS-1:0] v);
    drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    board.set_window(v);
    settings++;
  endtask

  task automatic run_phase(input logic [swm_pkg::CFG_BITS-1:0] win, input int count,
                           input bit hold_mid);
    bit gappy;
    set_size(win);
    gappy = $urandom_range(0, 1);
    for (int i = 0; i < count; i++) begin
      if (hold_mid && i == count / 2) drain();
      if (!calm && gappy && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 13));
      send_sample(rand_sample());
    end
  endtask

  initial begin
    int w;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    sin.valid <= 1'b0;
    sin.sample <= '0;
    rst_ni <= 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (edge_cases[i]) send_sample(edge_cases[i]);

    run_phase(7'd1, 30, 1'b0);
    run_phase(7'd0, 25, 1'b0);
    run_phase(7'd2, 40, 1'b0);
    run_phase(7'd127, 80, 1'b1);
    run_phase(7'd64, 80, 1'b0);
    run_phase(7'd4, 40, 1'b0);
    while (accepted < 570) begin
      if ($urandom_range(0, 1) != 0) w = $urandom_range(2, 12);
      else w = $urandom_range(1, 64);
      run_phase(7'(w), w + $urandom_range(10, 40), 1'b0);
    end
    calm = 1'b1;
    run_phase(7'($urandom_range(2, 9)), 70, 1'b0);

    drain();
    repeat (8) @(negedge clk_i);
    $display("covered %0d samples over %0d window settings, %0d medians checked",
             accepted, settings, board.checked);
    $display("windows 0, 1, 2, 64 and 127 written, full-scale and repeated samples; %0d errors",
             board.errors);
    if (board.errors == 0) begin
      $display("sliding_window_median regression: pass");
    end else begin
      $display("sliding_window_median regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
